[rtl/c3s_pkg.sv]
// Shared constants, types and register codes of the 3x3 smoothing filter.
package c3s_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int KERNEL_SIZE = 3;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int KROW_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = HEIGHT_W + 1;
  localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

  localparam int MIN_DIM    = 3;
  localparam int WIDTH_RST  = 512;
  localparam int HEIGHT_RST = 512;
  localparam logic [KROW_W-1:0] KROW_RST = 24'h010101;

  // arithmetic widths: pixel times coefficient, column sum, window sum
  localparam int PROD_W  = 2 * PIX_W + 1;
  localparam int CSUM_W  = PROD_W + 2;
  localparam int TOTAL_W = CSUM_W + 2;

  // divide by Kdiv through a reciprocal; sums at or above SAT_SUM clamp
  localparam int KDIV        = 9;
  localparam int PIX_MAX     = 255;
  localparam int SAT_SUM     = KDIV * (PIX_MAX + 1);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (2 ** RECIP_SHIFT + KDIV - 1) / KDIV;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int QIN_W       = $clog2(SAT_SUM);
  localparam int QPROD_W     = QIN_W + RECIP_W;

  typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] pix_col_t;
  typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] coef_col_t;
  typedef logic signed [CSUM_W-1:0]  csum_t;
  typedef logic signed [TOTAL_W-1:0] total_t;

  typedef struct packed {
    logic produce;
    logic border;
    logic last;
  } tag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_K_TOP  = 3'd2,
    REG_K_MID  = 3'd3,
    REG_K_BOT  = 3'd4
  } cfg_idx_e;

endpackage

[rtl/c3s_in_if.sv]
// Pixel input channel.
interface c3s_in_if;
  logic                       valid;
  logic                       ready;
  logic [c3s_pkg::PIX_W-1:0]  pixel_in;
  logic                       is_flush;

  modport source (output valid, pixel_in, is_flush, input ready);
  modport sink   (input valid, pixel_in, is_flush, output ready);
endinterface

[rtl/c3s_out_if.sv]
// Filtered pixel output channel.
interface c3s_out_if;
  logic                       valid;
  logic                       ready;
  logic [c3s_pkg::PIX_W-1:0]  pixel_out;
  logic                       is_border;
  logic                       frame_last;

  modport source (output valid, pixel_out, is_border, frame_last, input ready);
  modport sink   (input valid, pixel_out, is_border, frame_last, output ready);
endinterface

[rtl/c3s_cfg_if.sv]
// Configuration write channel.
interface c3s_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [c3s_pkg::CFG_IDX_W-1:0]   index;
  logic [c3s_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/c3s_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module c3s_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/c3s_pos.sv]
// Raster position tracker: classifies each input word and tags its output.
module c3s_pos (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  logic                           flush,
  input  logic [c3s_pkg::PIX_W-1:0]      pixel,
  input  logic [c3s_pkg::WIDTH_W-1:0]    w,
  input  logic [c3s_pkg::HEIGHT_W-1:0]   h,
  input  logic                           restart,
  output logic                           take,
  output logic [c3s_pkg::PIX_W-1:0]      x,
  output logic [c3s_pkg::COL_W-1:0]      col,
  output c3s_pkg::tag_t                  tag
);

  logic [c3s_pkg::COL_W-1:0] col_r, col_nxt;
  logic [c3s_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [c3s_pkg::ROW_W-1:0] orow, h_m1;
  logic [c3s_pkg::CMP_W-1:0] ocol, w_m1;
  logic                      drain, col_z, produce, border, last, col_wrap;

  always_comb begin
    drain    = row_r >= c3s_pkg::ROW_W'(h);
    take     = acc && (drain || !flush);
    x        = drain ? '0 : pixel;
    col_z    = col_r == '0;
    produce  = (row_r >= c3s_pkg::ROW_W'(2)) || (row_r == c3s_pkg::ROW_W'(1) && !col_z);
    h_m1     = c3s_pkg::ROW_W'(h) - c3s_pkg::ROW_W'(1);
    w_m1     = c3s_pkg::CMP_W'(w) - c3s_pkg::CMP_W'(1);
    // column zero emits the last pixel of the row before
    orow     = col_z ? row_r - c3s_pkg::ROW_W'(2) : row_r - c3s_pkg::ROW_W'(1);
    ocol     = col_z ? w_m1 : c3s_pkg::CMP_W'(col_r) - c3s_pkg::CMP_W'(1);
    border   = (orow == '0) || (orow >= h_m1) || (ocol == '0) || (ocol >= w_m1);
    last     = produce && (orow == h_m1) && (ocol == w_m1);
    col_wrap = c3s_pkg::CMP_W'(col_r) + c3s_pkg::CMP_W'(1) >= c3s_pkg::CMP_W'(w);

    tag.produce = take && produce;
    tag.border  = border;
    tag.last    = last;
    col         = col_r;

    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + c3s_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + c3s_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // a flush word inside the picture must leave the position alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !take && !restart) |=> ($stable(col_r) && $stable(row_r)))
    else $error("ignored flush word moved the raster position");

endmodule

[rtl/c3s_cell.sv]
// Window column cell: holds three pixels, hands them left, forms its weighted column sum.
module c3s_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                shift,
  input  c3s_pkg::pix_col_t   col_in,
  input  c3s_pkg::coef_col_t  coef,
  output c3s_pkg::pix_col_t   col_out,
  output c3s_pkg::csum_t      csum
);

  c3s_pkg::pix_col_t pix_r;
  logic signed [c3s_pkg::PROD_W-1:0] prod_r [c3s_pkg::KERNEL_SIZE];
  c3s_pkg::csum_t csum_r, csum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift) begin
      pix_r <= col_in;
    end
  end

  always_comb begin
    csum_nxt = '0;
    for (int i = 0; i < c3s_pkg::KERNEL_SIZE; i++) begin
      csum_nxt = csum_nxt + c3s_pkg::CSUM_W'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < c3s_pkg::KERNEL_SIZE; i++) begin
        prod_r[i] <= c3s_pkg::PROD_W'($signed({1'b0, pix_r[i]}))
                   * c3s_pkg::PROD_W'($signed(coef[i]));
      end
      csum_r <= csum_nxt;
    end
  end

  assign col_out = pix_r;
  assign csum    = csum_r;

endmodule

[rtl/conv3x3_smoothing_filter.sv]
// Top level of the 3x3 smoothing filter: config, line store, cell chain, divide and clamp.
//
//  channel  dir  handshake       payload
//  in_ch    in   valid / ready   pixel_in[7:0], is_flush
//  out_ch   out  valid / ready   pixel_out[7:0], is_border, frame_last
//  cfg_ch   in   valid / ready   index[2:0], data[23:0]
//
// One word per clock while the output is not stalled. The word that produces a result passes
// through the line store read, window shift, products, column sums, window sum, and
// divide and clamp before the result leaves the output register.
// rst_n is synchronous; it restores the default geometry and an all-ones kernel.
// A stalled output freezes the whole pipeline; in_ch.ready is high whenever the
// output register is empty or being taken. cfg_ch.ready is always high.
module conv3x3_smoothing_filter (
  input  logic  clk,
  input  logic  rst_n,
  c3s_in_if.sink    in_ch,
  c3s_out_if.source out_ch,
  c3s_cfg_if.sink   cfg_ch
);

  // ---------------- configuration ----------------
  logic [c3s_pkg::WIDTH_W-1:0]  width_r, w_eff;
  logic [c3s_pkg::HEIGHT_W-1:0] height_r, h_eff;
  logic [c3s_pkg::KROW_W-1:0]   krow_r [c3s_pkg::KERNEL_SIZE];
  logic                         cfg_we, restart;
  c3s_pkg::cfg_idx_e            cfg_idx;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;
  assign cfg_idx      = c3s_pkg::cfg_idx_e'(cfg_ch.index);
  assign restart      = cfg_we && (cfg_idx == c3s_pkg::REG_WIDTH ||
                                   cfg_idx == c3s_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= c3s_pkg::WIDTH_W'(c3s_pkg::WIDTH_RST);
      height_r  <= c3s_pkg::HEIGHT_W'(c3s_pkg::HEIGHT_RST);
      krow_r[0] <= c3s_pkg::KROW_RST;
      krow_r[1] <= c3s_pkg::KROW_RST;
      krow_r[2] <= c3s_pkg::KROW_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        c3s_pkg::REG_WIDTH:  width_r   <= cfg_ch.data[c3s_pkg::WIDTH_W-1:0];
        c3s_pkg::REG_HEIGHT: height_r  <= cfg_ch.data[c3s_pkg::HEIGHT_W-1:0];
        c3s_pkg::REG_K_TOP:  krow_r[0] <= cfg_ch.data[c3s_pkg::KROW_W-1:0];
        c3s_pkg::REG_K_MID:  krow_r[1] <= cfg_ch.data[c3s_pkg::KROW_W-1:0];
        c3s_pkg::REG_K_BOT:  krow_r[2] <= cfg_ch.data[c3s_pkg::KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < c3s_pkg::WIDTH_W'(c3s_pkg::MIN_DIM)) begin
      w_eff = c3s_pkg::WIDTH_W'(c3s_pkg::MIN_DIM);
    end else if (32'(width_r) > c3s_pkg::MAX_WIDTH) begin
      w_eff = c3s_pkg::WIDTH_W'(c3s_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < c3s_pkg::HEIGHT_W'(c3s_pkg::MIN_DIM)) begin
      h_eff = c3s_pkg::HEIGHT_W'(c3s_pkg::MIN_DIM);
    end else begin
      h_eff = height_r;
    end
  end

  // ---------------- input stage ----------------
  logic                        pipe_en, in_acc, take;
  logic [c3s_pkg::PIX_W-1:0]   x;
  logic [c3s_pkg::COL_W-1:0]   col;
  c3s_pkg::tag_t               tag;
  logic                        out_valid_r;

  assign pipe_en     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = pipe_en;
  assign in_acc      = in_ch.valid && pipe_en;

  c3s_pos u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .flush   (in_ch.is_flush),
    .pixel   (in_ch.pixel_in),
    .w       (w_eff),
    .h       (h_eff),
    .restart (restart),
    .take    (take),
    .x       (x),
    .col     (col),
    .tag     (tag)
  );

  // ---------------- line store ----------------
  // upper row in the high byte, lower row in the low byte
  logic [2*c3s_pkg::PIX_W-1:0] rdata;
  logic                        b_take_r, ram_we;
  logic [c3s_pkg::PIX_W-1:0]   b_x_r;
  logic [c3s_pkg::COL_W-1:0]   b_col_r;
  c3s_pkg::tag_t               b_tag_r;

  assign ram_we = pipe_en && b_take_r;

  c3s_ram #(
    .WIDTH (2 * c3s_pkg::PIX_W),
    .DEPTH (c3s_pkg::MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_col_r),
    .wdata ({rdata[c3s_pkg::PIX_W-1:0], b_x_r}),
    .re    (take),
    .raddr (col),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_take_r <= 1'b0;
      b_tag_r  <= '0;
    end else if (pipe_en) begin
      b_take_r <= take;
      b_tag_r  <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_x_r   <= x;
      b_col_r <= col;
    end
  end

  // ---------------- cell chain ----------------
  c3s_pkg::pix_col_t  new_col;
  c3s_pkg::pix_col_t  col_bus  [c3s_pkg::KERNEL_SIZE];
  c3s_pkg::coef_col_t coef_bus [c3s_pkg::KERNEL_SIZE];
  c3s_pkg::csum_t     csum_bus [c3s_pkg::KERNEL_SIZE];

  // top row from the upper store, bottom row is the incoming pixel
  assign new_col = {b_x_r, rdata[c3s_pkg::PIX_W-1:0],
                    rdata[2*c3s_pkg::PIX_W-1:c3s_pkg::PIX_W]};

  for (genvar k = 0; k < c3s_pkg::KERNEL_SIZE; k++) begin : g_cell
    assign coef_bus[k] = {krow_r[2][c3s_pkg::PIX_W*k +: c3s_pkg::PIX_W],
                          krow_r[1][c3s_pkg::PIX_W*k +: c3s_pkg::PIX_W],
                          krow_r[0][c3s_pkg::PIX_W*k +: c3s_pkg::PIX_W]};
    if (k == c3s_pkg::KERNEL_SIZE - 1) begin : g_head
      c3s_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .shift   (ram_we),
        .col_in  (new_col),
        .coef    (coef_bus[k]),
        .col_out (col_bus[k]),
        .csum    (csum_bus[k])
      );
    end else begin : g_body
      c3s_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .shift   (ram_we),
        .col_in  (col_bus[k+1]),
        .coef    (coef_bus[k]),
        .col_out (col_bus[k]),
        .csum    (csum_bus[k])
      );
    end
  end

  // ---------------- tag line and window sum ----------------
  c3s_pkg::tag_t             c_tag_r, d_tag_r, e_tag_r, f_tag_r;
  logic [c3s_pkg::PIX_W-1:0] d_ctr_r, e_ctr_r, f_ctr_r;
  c3s_pkg::total_t           total_r, total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_tag_r <= '0;
      d_tag_r <= '0;
      e_tag_r <= '0;
      f_tag_r <= '0;
    end else if (pipe_en) begin
      c_tag_r <= b_tag_r;
      d_tag_r <= c_tag_r;
      e_tag_r <= d_tag_r;
      f_tag_r <= e_tag_r;
    end
  end

  always_comb begin
    total_nxt = '0;
    for (int k = 0; k < c3s_pkg::KERNEL_SIZE; k++) begin
      total_nxt = total_nxt + c3s_pkg::TOTAL_W'(csum_bus[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d_ctr_r <= col_bus[1][1];
      e_ctr_r <= d_ctr_r;
      f_ctr_r <= e_ctr_r;
      total_r <= total_nxt;
    end
  end

  // ---------------- divide, clamp, output register ----------------
  logic [c3s_pkg::QPROD_W-1:0] qprod;
  logic [c3s_pkg::PIX_W-1:0]   filt;
  logic [c3s_pkg::PIX_W-1:0]   out_pix_r;
  logic                        out_border_r, out_last_r;

  // exact quotient for sums below the clamp limit
  assign qprod = c3s_pkg::QPROD_W'(total_r[c3s_pkg::QIN_W-1:0])
               * c3s_pkg::QPROD_W'(c3s_pkg::RECIP);

  always_comb begin
    if (total_r < 0) begin
      filt = '0;
    end else if (total_r >= $signed(c3s_pkg::TOTAL_W'(c3s_pkg::SAT_SUM))) begin
      filt = c3s_pkg::PIX_W'(c3s_pkg::PIX_MAX);
    end else begin
      filt = qprod[c3s_pkg::RECIP_SHIFT +: c3s_pkg::PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= f_tag_r.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_pix_r    <= f_tag_r.border ? f_ctr_r : filt;
      out_border_r <= f_tag_r.border;
      out_last_r   <= f_tag_r.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_out  = out_pix_r;
  assign out_ch.is_border  = out_border_r;
  assign out_ch.frame_last = out_last_r;

  // ---------------- checks ----------------
  // the final pixel of a frame is a corner, so it is always a border word
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_border_r)
    else $error("frame_last on an interior pixel");

  // a result only appears when the last stage carried one
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(f_tag_r.produce))
    else $error("output word without a pending result");

  // a pending result must survive a stall
  assert property (@(posedge clk) disable iff (!rst_n)
    (f_tag_r.produce && !pipe_en) |=> f_tag_r.produce)
    else $error("pending result lost during a stall");

endmodule
